// ----- hw/rtl/plate_hash_table_unit_assert.svh -----
// assertion macros for the plate hash table
`ifndef PLATE_HASH_TABLE_UNIT_ASSERT_SVH
`define PLATE_HASH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define PHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plate_hash_table_unit: check failed");

// next-cycle implication, held off during reset
`define PHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plate_hash_table_unit: check failed");

`endif

// ----- hw/rtl/pht_pkg.sv -----
package pht_pkg;

    // default geometry
    localparam int TABLE_SIZE_DEF = 1201;
    localparam int KEY_CHARS_DEF  = 7;

    // hash and probe step constants
    localparam int HASH_BASE  = 37;
    localparam int STEP_CONST = 37;
    localparam int STEP_MOD   = 1103;

    // fixed field widths
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 32;

    // character classes
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A_UP = 8'h41;
    localparam logic [7:0] CHAR_Z_UP = 8'h5A;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_KEY   = 2'd3;

    // sequencer states
    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_HASH   = 9'b000000100,
        ST_REDUCE = 9'b000001000,
        ST_MULT   = 9'b000010000,
        ST_ADD    = 9'b000100000,
        ST_READ   = 9'b001000000,
        ST_CHECK  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    // what the shared remainder unit is working on
    typedef enum logic [2:0] {
        PH_HASH = 3'b001,
        PH_STEP = 3'b010,
        PH_SLOT = 3'b100
    } phase_t;

endpackage

// ----- hw/rtl/plate_hash_table_unit.sv -----
// Plate hash table: open-addressed table of short text keys.
// Request channel (req_valid / req_stall): mode (insert, find, remove) and key,
// first character in the top byte. Response channel (rsp_valid / rsp_stall):
// status, slot_index, probe_count and the running insert collision total.
// One request is worked on at a time; req_stall is high while busy.
// All remainders go through one shared compare-subtract unit, one shifted
// divisor per cycle. Steps: the request is taken, then each key character
// that is a digit or capital is loaded and reduced (one load plus 6 subtract
// steps) and any other character is skipped, the home slot is read and
// tested, and each collision takes slot mod 1103, one multiply, one add, 11
// subtract steps and a memory read and test; then the result is handed over.
// After reset a clearing pass walks the table, one slot per cycle, over all
// TABLE_SIZE slots; no request is taken during it.
// The response sits in an output register; while the receiver stalls, the
// next request may still be taken and worked on, and its result waits until
// the register is free.
`include "plate_hash_table_unit_assert.svh"

module plate_hash_table_unit #(
    parameter int TABLE_SIZE = pht_pkg::TABLE_SIZE_DEF,
    parameter int KEY_CHARS  = pht_pkg::KEY_CHARS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic [pht_pkg::MODE_W-1:0]            mode,
    input  logic [8*KEY_CHARS-1:0]                key,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic [pht_pkg::STATUS_W-1:0]          status,
    output logic [$clog2(TABLE_SIZE)-1:0]         slot_index,
    output logic [$clog2(TABLE_SIZE+1)-1:0]       probe_count,
    output logic [pht_pkg::TOTAL_W-1:0]           total_collisions
);
    import pht_pkg::*;

    localparam int KEY_W   = 8 * KEY_CHARS;
    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int PROBE_W = $clog2(TABLE_SIZE + 1);
    localparam int CHAR_W  = $clog2(KEY_CHARS + 1);
    localparam int MOD_W   = $clog2(STEP_MOD);
    localparam int PROD_W  = PROBE_W + MOD_W;
    // largest value the remainder unit sees: slot + 37 + probes * 1102
    localparam int REM_W   = $clog2(TABLE_SIZE * (STEP_MOD + 1) + STEP_CONST + 1);
    // subtract steps per reduction
    localparam int HASH_STEPS = $clog2(HASH_BASE);
    localparam int PROBE_STEPS = $clog2(STEP_MOD + 2);
    localparam int MOD_RAW = $clog2((TABLE_SIZE + STEP_MOD - 1) / STEP_MOD);
    localparam int MOD_STEPS = (MOD_RAW == 0) ? 1 : MOD_RAW;
    localparam int STEP_W = $clog2(PROBE_STEPS);

    // control registers
    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [SLOT_W-1:0]      clr_reg, clr_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // working registers
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [KEY_W-1:0]       hkey_reg, hkey_next;
    logic [CHAR_W-1:0]      char_cnt_reg, char_cnt_next;
    logic [SLOT_W-1:0]      hash_reg, hash_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [PROBE_W-1:0]     probe_reg, probe_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [PROBE_W-1:0]     res_probe_reg, res_probe_next;
    logic [STATUS_W-1:0]    rsp_status_reg, rsp_status_next;
    logic [SLOT_W-1:0]      rsp_slot_reg, rsp_slot_next;
    logic [PROBE_W-1:0]     rsp_probe_reg, rsp_probe_next;
    logic [TOTAL_W-1:0]     rsp_total_reg, rsp_total_next;

    // table memory: used flag over stored key
    logic [KEY_W:0]         table_mem [TABLE_SIZE];
    logic [KEY_W:0]         rd_word_reg;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_addr;
    logic [KEY_W:0]         mem_wdata;

    // combinational helpers
    logic [KEY_W-1:0]       key_canon;
    logic                   key_alive;
    logic [7:0]             cur_byte;
    logic                   is_digit;
    logic                   is_letter;
    logic [4:0]             char_val;
    logic [REM_W-1:0]       div_val;
    logic [REM_W-1:0]       div_shift;
    logic [REM_W:0]         trial;
    logic [REM_W-1:0]       rem_sub;
    logic                   slot_used;
    logic                   slot_match;
    logic                   slot_hit;
    logic [PROBE_W-1:0]     probe_plus;
    logic [TOTAL_W:0]       total_sum;
    logic                   rsp_free;

    // key ends at its first zero byte
    always_comb
    begin
        key_canon = '0;
        key_alive = 1'b1;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            if (key[KEY_W-1-8*i -: 8] == 8'd0)
            begin
                key_alive = 1'b0;
            end
            if (key_alive)
            begin
                key_canon[KEY_W-1-8*i -: 8] = key[KEY_W-1-8*i -: 8];
            end
        end
    end

    // character value of the byte at the head of the hash shifter
    assign cur_byte  = hkey_reg[KEY_W-1 -: 8];
    assign is_digit  = (cur_byte >= CHAR_ZERO) && (cur_byte <= CHAR_NINE);
    assign is_letter = (cur_byte >= CHAR_A_UP) && (cur_byte <= CHAR_Z_UP);
    always_comb
    begin
        if (is_digit)
        begin
            char_val = 5'(cur_byte - CHAR_ZERO);
        end
        else
        begin
            char_val = 5'(cur_byte - CHAR_A_UP);
        end
    end

    // shared compare-subtract unit
    assign div_val   = (phase_reg == PH_STEP) ? REM_W'(STEP_MOD) : REM_W'(TABLE_SIZE);
    assign div_shift = div_val << step_reg;
    assign trial     = {1'b0, rem_reg} - {1'b0, div_shift};
    assign rem_sub   = trial[REM_W] ? rem_reg : trial[REM_W-1:0];

    // slot test
    assign slot_used  = rd_word_reg[KEY_W];
    assign slot_match = slot_used && (rd_word_reg[KEY_W-1:0] == key_reg);
    assign slot_hit   = (mode_reg == MODE_INSERT) ? !slot_used : slot_match;
    assign probe_plus = probe_reg + PROBE_W'(1);
    assign total_sum  = {1'b0, total_reg} + (TOTAL_W+1)'(probe_reg);

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        clr_next        = clr_reg;
        total_next      = total_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        mode_next       = mode_reg;
        key_next        = key_reg;
        hkey_next       = hkey_reg;
        char_cnt_next   = char_cnt_reg;
        hash_next       = hash_reg;
        slot_next       = slot_reg;
        probe_next      = probe_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_probe_next  = res_probe_reg;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_probe_next  = rsp_probe_reg;
        rsp_total_next  = rsp_total_reg;
        mem_we          = 1'b0;
        mem_addr        = slot_reg;
        mem_wdata       = {1'b0, key_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                // free every slot after reset
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                if (clr_reg == SLOT_W'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + SLOT_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next      = mode;
                    key_next       = key_canon;
                    hkey_next      = key_canon;
                    char_cnt_next  = '0;
                    hash_next      = '0;
                    probe_next     = '0;
                    res_slot_next  = '0;
                    res_probe_next = '0;
                    if (key_canon[KEY_W-1 -: 8] == 8'd0)
                    begin
                        res_status_next = STATUS_BAD_KEY;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        unique case (mode)
                            MODE_INSERT, MODE_FIND, MODE_REMOVE:
                            begin
                                state_next = ST_HASH;
                            end
                            default:
                            begin
                                res_status_next = STATUS_NOT_FOUND;
                                state_next      = ST_DONE;
                            end
                        endcase
                    end
                end
            end
            ST_HASH:
            begin
                // consume one key character
                hkey_next = hkey_reg << 8;
                if (is_digit || is_letter)
                begin
                    rem_next   = REM_W'(hash_reg) * REM_W'(HASH_BASE) + REM_W'(char_val);
                    step_next  = STEP_W'(HASH_STEPS - 1);
                    phase_next = PH_HASH;
                    state_next = ST_REDUCE;
                end
                else if (char_cnt_reg == CHAR_W'(KEY_CHARS - 1))
                begin
                    slot_next  = hash_reg;
                    state_next = ST_READ;
                end
                else
                begin
                    char_cnt_next = char_cnt_reg + CHAR_W'(1);
                end
            end
            ST_REDUCE:
            begin
                rem_next  = rem_sub;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    unique case (phase_reg)
                        PH_HASH:
                        begin
                            hash_next = rem_sub[SLOT_W-1:0];
                            if (char_cnt_reg == CHAR_W'(KEY_CHARS - 1))
                            begin
                                slot_next  = rem_sub[SLOT_W-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                char_cnt_next = char_cnt_reg + CHAR_W'(1);
                                state_next    = ST_HASH;
                            end
                        end
                        PH_STEP:
                        begin
                            state_next = ST_MULT;
                        end
                        PH_SLOT:
                        begin
                            slot_next  = rem_sub[SLOT_W-1:0];
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MULT:
            begin
                // probe count times (slot mod 1103)
                prod_next  = PROD_W'(probe_reg) * PROD_W'(rem_reg[MOD_W-1:0]);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                rem_next   = REM_W'(slot_reg) + REM_W'(STEP_CONST) + REM_W'(prod_reg);
                step_next  = STEP_W'(PROBE_STEPS - 1);
                phase_next = PH_SLOT;
                state_next = ST_REDUCE;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (slot_hit)
                begin
                    res_status_next = STATUS_OK;
                    res_slot_next   = slot_reg;
                    res_probe_next  = probe_reg;
                    if (mode_reg == MODE_INSERT)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = {1'b1, key_reg};
                        total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                    end
                    else if (mode_reg == MODE_REMOVE)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b0, key_reg};
                    end
                    state_next = ST_DONE;
                end
                else if (probe_plus == PROBE_W'(TABLE_SIZE))
                begin
                    // walk limit reached
                    res_status_next = (mode_reg == MODE_INSERT) ? STATUS_FULL
                                                                : STATUS_NOT_FOUND;
                    res_slot_next   = '0;
                    res_probe_next  = probe_plus;
                    state_next      = ST_DONE;
                end
                else
                begin
                    // next slot: start with slot mod 1103
                    probe_next = probe_plus;
                    rem_next   = REM_W'(slot_reg);
                    step_next  = STEP_W'(MOD_STEPS - 1);
                    phase_next = PH_STEP;
                    state_next = ST_REDUCE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = res_slot_reg;
                    rsp_probe_next  = res_probe_reg;
                    rsp_total_next  = total_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_HASH;
            clr_reg       <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        hkey_reg       <= hkey_next;
        char_cnt_reg   <= char_cnt_next;
        hash_reg       <= hash_next;
        slot_reg       <= slot_next;
        probe_reg      <= probe_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_probe_reg  <= res_probe_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_probe_reg  <= rsp_probe_next;
        rsp_total_reg  <= rsp_total_next;
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_addr] <= mem_wdata;
        end
        rd_word_reg <= table_mem[slot_reg];
    end

    // ports
    assign req_stall        = (state_reg != ST_IDLE);
    assign rsp_valid        = rsp_valid_reg;
    assign status           = rsp_status_reg;
    assign slot_index       = rsp_slot_reg;
    assign probe_count      = rsp_probe_reg;
    assign total_collisions = rsp_total_reg;

    // checks
    `PHT_ASSERT_IMP(a_fail_slot_zero, clk, rst_n, rsp_valid_reg && (rsp_status_reg != STATUS_OK), rsp_slot_reg == '0)
    `PHT_ASSERT_IMP(a_slot_in_range, clk, rst_n, state_reg == ST_READ, {1'b0, slot_reg} < (SLOT_W+1)'(TABLE_SIZE))
    `PHT_ASSERT_IMP(a_total_grows, clk, rst_n, 1'b1, total_reg >= $past(total_reg))
    `PHT_ASSERT_NXT(a_rsp_from_done, clk, rst_n, (state_reg != ST_DONE) && !rsp_valid_reg, !rsp_valid_reg)

endmodule
